FILE: hw/rtl/mfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_pkg: shared types and constants
// Field widths, fixed-point constants, cell control word and the CORDIC
// cosine used to build the DCT coefficient table at elaboration.
// ----------------------------------------------------------------------------
package mfb_pkg;

   localparam int SUM_W    = 48;   // band sum, Q16.16 with headroom
   localparam int LOG_W    = 24;   // log10, Q7.16
   localparam int COS_W    = 18;   // cosine, Q1.16
   localparam int EDGE_W   = 8;
   localparam int POWER_W  = 32;
   localparam int NUM_W    = 40;   // power times weight
   localparam int DIV_STEPS = 40;
   localparam int COEF_W   = 32;
   localparam int IDX_W    = 4;

   // request word kinds, carried on tuser
   localparam logic CMD_EDGE = 1'b0;   // edge table write
   localparam logic CMD_BIN  = 1'b1;   // spectrum bin

   localparam logic signed [LOG_W-1:0] LOG_MIN = 24'sh800000;
   localparam logic [29:0] LOG10_2_Q30 = 30'd323228497;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint CORDIC_GAIN_Q30 = 64'sd652032875;
   localparam int CORDIC_STEPS = 24;

   localparam longint ATAN_Q30 [16] = '{
      64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
      64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
      64'sd4194283, 64'sd2097149, 64'sd1048576, 64'sd524288,
      64'sd262144, 64'sd131072, 64'sd65536, 64'sd32768
   };

   // control word broadcast to every filter cell
   typedef struct packed {
      logic start;   // load product and divisor
      logic div;     // one restoring divider step
      logic commit;  // add quotient into the band sum
      logic shift;   // take neighbor's value
      logic clear;   // zero the band sum
   } cell_ctrl_type;

   // CORDIC cosine of a quadrant plus residual angle, rounded to Q16
   function automatic logic signed [COS_W-1:0] cordic_cos(longint z_in, int quad);
      longint x, y, z, nx, ny, t, c;
      logic [1:0] q;
      x = CORDIC_GAIN_Q30;
      y = 0;
      z = z_in;
      q = quad[1:0];
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         t = (i < 16) ? ATAN_Q30[i] : (64'sd1 <<< (30 - i));
         if (z >= 0) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z = z - t;
         end else begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z = z + t;
         end
         x = nx;
         y = ny;
      end
      unique case (q)
         2'd0: c = x;
         2'd1: c = -y;
         2'd2: c = -x;
         default: c = y;
      endcase
      c = (c + 64'sd8192) >>> 14;
      return c[COS_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/mfb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_cell: one triangular filter
// Weighs the current bin by its rising or falling slope with a bit-serial
// divider, accumulates with saturation, and shifts along the chain.
// ----------------------------------------------------------------------------
module mfb_cell #(
   parameter int JW = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mfb_pkg::cell_ctrl_type        ctrl,
   input  logic [JW-1:0]                 bin_idx,
   input  logic [mfb_pkg::POWER_W-1:0]   power,
   input  logic [mfb_pkg::EDGE_W-1:0]    e0,
   input  logic [mfb_pkg::EDGE_W-1:0]    e1,
   input  logic [mfb_pkg::EDGE_W-1:0]    e2,
   input  logic [mfb_pkg::SUM_W-1:0]     shift_in,
   output logic [mfb_pkg::SUM_W-1:0]     value
);
   import mfb_pkg::*;

   localparam int XW = (JW > EDGE_W) ? JW : EDGE_W;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [EDGE_W-1:0] rem_ff, rem_in;
   logic [EDGE_W-1:0] den_ff, den_in;

   logic [XW-1:0] jx, x0, x1, x2;
   logic          rise, fall;
   logic [EDGE_W-1:0] weight, den;
   logic [EDGE_W:0]   trial;
   logic [EDGE_W:0]   diff;
   logic [SUM_W:0]    total;

   // slope selection
   always_comb begin
      jx = XW'(bin_idx);
      x0 = XW'(e0);
      x1 = XW'(e1);
      x2 = XW'(e2);
      rise = (x0 <= jx) && (jx < x1);
      fall = (x1 <= jx) && (jx < x2);
      weight = '0;
      den = 8'd1;
      if (rise) begin
         weight = EDGE_W'(jx - x0);
         den = e1 - e0;
      end else if (fall) begin
         weight = EDGE_W'(x2 - jx);
         den = e2 - e1;
      end
   end

   // divider step and saturating accumulate
   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      diff = trial - {1'b0, den_ff};
      total = {1'b0, sum_ff} + {{(SUM_W+1-NUM_W){1'b0}}, num_ff};
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (ctrl.start) begin
         num_in = NUM_W'(power * weight);
         rem_in = '0;
         den_in = den;
      end else if (ctrl.div) begin
         if (!diff[EDGE_W]) begin
            rem_in = diff[EDGE_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[EDGE_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
      end
      priority if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.shift) begin
         sum_in = shift_in;
      end else if (ctrl.commit) begin
         sum_in = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign value = sum_ff;

endmodule

FILE: hw/rtl/mfb_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_log: iterative log10
// Normalizes one bit a cycle, takes 16 fraction bits by repeated squaring,
// then scales by log10(2) with round to nearest.
// ----------------------------------------------------------------------------
module mfb_log (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mfb_pkg::SUM_W-1:0]         value,
   output logic                              done,
   output logic signed [mfb_pkg::LOG_W-1:0]  result
);
   import mfb_pkg::*;

   typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQR, L_MUL, L_RND} lstate_type;

   lstate_type         state_ff;
   logic [SUM_W-1:0]   x_ff;
   logic [5:0]         k_ff;
   logic [30:0]        m_ff;
   logic [15:0]        frac_ff;
   logic [3:0]         cnt_ff;
   logic               neg_ff;
   logic [51:0]        prod_ff;
   logic signed [LOG_W-1:0] res_ff;
   logic               done_ff;

   logic [61:0]        sq;
   logic [31:0]        sqs;
   logic signed [6:0]  kd;
   logic signed [22:0] l2;
   logic [21:0]        mag;
   logic [LOG_W-1:0]   r;

   always_comb begin
      sq = 62'(m_ff * m_ff);
      sqs = sq[61:30];
      kd = $signed({1'b0, k_ff}) - 7'sd16;
      l2 = {kd, frac_ff};
      mag = l2[22] ? 22'(-l2) : 22'(l2);
      r = prod_ff[30 +: LOG_W];
   end

   // sequencer with registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            L_IDLE: begin
               if (start) begin
                  if (value == '0) begin
                     res_ff  <= LOG_MIN;
                     done_ff <= 1'b1;
                  end else begin
                     x_ff     <= value;
                     k_ff     <= 6'd47;
                     state_ff <= L_NORM;
                  end
               end
            end
            L_NORM: begin
               if (x_ff[SUM_W-1]) begin
                  m_ff     <= x_ff[SUM_W-1 -: 31];
                  frac_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= L_SQR;
               end else begin
                  x_ff <= {x_ff[SUM_W-2:0], 1'b0};
                  k_ff <= k_ff - 6'd1;
               end
            end
            L_SQR: begin
               if (sqs[31]) begin
                  m_ff    <= sqs[31:1];
                  frac_ff <= {frac_ff[14:0], 1'b1};
               end else begin
                  m_ff    <= sqs[30:0];
                  frac_ff <= {frac_ff[14:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  state_ff <= L_MUL;
               end
            end
            L_MUL: begin
               prod_ff  <= 52'(mag * LOG10_2_Q30) + (52'd1 << 29);
               neg_ff   <= l2[22];
               state_ff <= L_RND;
            end
            L_RND: begin
               res_ff   <= neg_ff ? $signed(-r) : $signed(r);
               done_ff  <= 1'b1;
               state_ff <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign result = res_ff;

endmodule

FILE: hw/rtl/mel_filterbank_log_dct_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mel_filterbank_log_dct_core: mel filterbank, log10 and DCT-II
// Triangular filter chain over loaded edges, then cepstral coefficients.
// ----------------------------------------------------------------------------
// Every filter cell weighs a spectrum bin in parallel through its own
// bit-serial divider of 40 steps. On the last bin of a frame the band sums
// shift one by one out of the cell chain through a shared log unit (its time
// per band goes mostly to the normalizing shift and 16 squarings) and back
// into the chain; each coefficient is then summed as the log ring rotates
// past one multiplier, and the next coefficient starts once the last one is
// loaded into the output register, which waits until the word before is taken.
// A new request word is accepted only while the core is idle, between bins.
module mel_filterbank_log_dct_core #(
   parameter int NUM_FILTERS = 26,
   parameter int FRAME_LEN   = 512,
   parameter int NUM_COEFFS  = 13
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // edge_slot[4:0], edge_bin[12:5], bin_power[44:13]
   input  logic        req_tuser,  // command
   input  logic        req_tlast,  // last_bin
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // coefficient[31:0], coeff_index[35:32]
   output logic        rsp_tlast   // last_coeff
);
   import mfb_pkg::*;

   localparam int EDGES = NUM_FILTERS + 2;
   localparam int EW    = $clog2(EDGES);
   localparam int JW    = $clog2(FRAME_LEN);
   localparam int NW    = $clog2(NUM_FILTERS);
   localparam int KW    = $clog2(NUM_COEFFS + 1);
   localparam int ANG   = 4 * NUM_FILTERS;
   localparam int AW    = $clog2(ANG);
   localparam int ACC_W = 48;
   localparam int PROD_W = LOG_W + COS_W;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_DIV, S_COMMIT, S_LOG_START, S_LOG_WAIT,
      S_DCT, S_FLUSH, S_EMIT
   } state_type;

   // cosine table built at elaboration
   logic signed [COS_W-1:0] cos_tab [ANG];
   for (genvar a = 0; a < ANG; a++) begin : g_cos
      localparam int QD = a / NUM_FILTERS;
      localparam int RM = a % NUM_FILTERS;
      localparam longint ZR = (longint'(RM) * HALF_PI_Q30) / NUM_FILTERS;
      assign cos_tab[a] = cordic_cos(ZR, QD);
   end

   state_type            state_ff;
   logic [EDGE_W-1:0]    edge_ff [EDGES];
   logic [JW-1:0]        bin_ff;
   logic [POWER_W-1:0]   power_ff;
   logic                 last_ff;
   logic [5:0]           step_ff;
   logic [NW-1:0]        n_ff;
   logic [KW-1:0]        k_ff;
   logic [AW-1:0]        base_ff, inc_ff, ang_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                 prod_v_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                 log_start_ff;
   logic                 out_v_ff;
   logic [COEF_W-1:0]    out_coef_ff;
   logic [IDX_W-1:0]     out_idx_ff;
   logic                 out_last_ff;

   cell_ctrl_type        ctrl;
   logic [SUM_W-1:0]     cell_val [NUM_FILTERS];
   logic [SUM_W-1:0]     tail_in;
   logic                 log_done;
   logic signed [LOG_W-1:0] log_res;

   logic                 accept;
   logic [EW-1:0]        slot_idx;
   logic [AW:0]          ang_sum, base_sum, inc_sum;
   logic signed [ACC_W+1:0]  rnd;
   logic signed [ACC_W-15:0] shv;
   logic [COEF_W-1:0]    sat;
   logic                 out_free;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign slot_idx = EW'(req_tdata[4:0]);
   assign out_free = !out_v_ff || rsp_tready;

   // cell control and chain feed
   always_comb begin
      ctrl = '0;
      ctrl.start  = (state_ff == S_START);
      ctrl.div    = (state_ff == S_DIV);
      ctrl.commit = (state_ff == S_COMMIT);
      ctrl.shift  = ((state_ff == S_LOG_WAIT) && log_done) || (state_ff == S_DCT);
      ctrl.clear  = (state_ff == S_EMIT) && out_free && (k_ff == KW'(NUM_COEFFS - 1));
      tail_in = (state_ff == S_DCT) ? cell_val[0] : SUM_W'(log_res);
   end

   for (genvar i = 0; i < NUM_FILTERS; i++) begin : g_cell
      mfb_cell #(.JW(JW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .bin_idx  (bin_ff),
         .power    (power_ff),
         .e0       (edge_ff[i]),
         .e1       (edge_ff[i+1]),
         .e2       (edge_ff[i+2]),
         .shift_in ((i == NUM_FILTERS - 1) ? tail_in : cell_val[(i + 1) % NUM_FILTERS]),
         .value    (cell_val[i])
      );
   end

   mfb_log u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start_ff),
      .value  (cell_val[0]),
      .done   (log_done),
      .result (log_res)
   );

   // angle stepping and output rounding
   always_comb begin
      ang_sum  = {1'b0, ang_ff} + {1'b0, inc_ff};
      if (ang_sum >= (AW+1)'(ANG)) ang_sum = ang_sum - (AW+1)'(ANG);
      base_sum = {1'b0, base_ff} + (AW+1)'(1);
      if (base_sum >= (AW+1)'(ANG)) base_sum = base_sum - (AW+1)'(ANG);
      inc_sum  = {1'b0, inc_ff} + (AW+1)'(2);
      if (inc_sum >= (AW+1)'(ANG)) inc_sum = inc_sum - (AW+1)'(ANG);
      rnd = {acc_ff[ACC_W-1], acc_ff, 1'b0} + (ACC_W+2)'(32768);
      shv = rnd[ACC_W+1:16];
      if (shv > (ACC_W-14)'(64'sh7FFFFFFF)) begin
         sat = 32'h7FFFFFFF;
      end else if (shv < -(ACC_W-14)'(64'sh80000000)) begin
         sat = 32'h80000000;
      end else begin
         sat = shv[COEF_W-1:0];
      end
   end

   // edge table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < EDGES; i++) edge_ff[i] <= '0;
      end else if (accept && (req_tuser == CMD_EDGE) && (int'(req_tdata[4:0]) < EDGES)) begin
         edge_ff[slot_idx] <= req_tdata[12:5];
      end
   end

   // product and accumulator; the sum holds until it is loaded into the output register
   always_ff @(posedge clock) begin
      prod_ff <= $signed(cell_val[0][LOG_W-1:0]) * cos_tab[ang_ff];
      if ((state_ff == S_EMIT && out_free) || state_ff == S_LOG_WAIT) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // frame sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bin_ff       <= '0;
         prod_v_ff    <= 1'b0;
         log_start_ff <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         log_start_ff <= 1'b0;
         prod_v_ff    <= (state_ff == S_DCT);
         if (out_v_ff && rsp_tready) out_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept && (req_tuser == CMD_BIN)) begin
                  power_ff <= req_tdata[44:13];
                  last_ff  <= req_tlast;
                  state_ff <= S_START;
               end
            end
            S_START: begin
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'(DIV_STEPS - 1)) state_ff <= S_COMMIT;
            end
            S_COMMIT: begin
               if (bin_ff < JW'(FRAME_LEN - 1)) bin_ff <= bin_ff + JW'(1);
               n_ff <= '0;
               if (last_ff) begin
                  log_start_ff <= 1'b1;
                  state_ff     <= S_LOG_WAIT;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_LOG_START: begin
               log_start_ff <= 1'b1;
               state_ff     <= S_LOG_WAIT;
            end
            S_LOG_WAIT: begin
               if (log_done) begin
                  n_ff <= n_ff + NW'(1);
                  if (n_ff == NW'(NUM_FILTERS - 1)) begin
                     k_ff     <= '0;
                     base_ff  <= '0;
                     inc_ff   <= '0;
                     ang_ff   <= '0;
                     n_ff     <= '0;
                     state_ff <= S_DCT;
                  end else begin
                     state_ff <= S_LOG_START;
                  end
               end
            end
            S_DCT: begin
               ang_ff <= ang_sum[AW-1:0];
               n_ff   <= n_ff + NW'(1);
               if (n_ff == NW'(NUM_FILTERS - 1)) state_ff <= S_FLUSH;
            end
            S_FLUSH: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  out_v_ff    <= 1'b1;
                  out_coef_ff <= sat;
                  out_idx_ff  <= IDX_W'(k_ff);
                  out_last_ff <= (k_ff == KW'(NUM_COEFFS - 1));
                  n_ff        <= '0;
                  if (k_ff == KW'(NUM_COEFFS - 1)) begin
                     bin_ff   <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + KW'(1);
                     base_ff  <= base_sum[AW-1:0];
                     inc_ff   <= inc_sum[AW-1:0];
                     ang_ff   <= base_sum[AW-1:0];
                     state_ff <= S_DCT;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'd0, out_idx_ff, out_coef_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
